// ===== hdl/brc_pkg.sv =====
package brc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAL_A = 3'd0,
    CFG_CAL_B = 3'd1,
    CFG_CAL_C = 3'd2,
    CFG_CAL_D = 3'd3,
    CFG_OSS   = 3'd4
  } cfg_idx_e;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] Half15     = 32'd32768;
  localparam logic [15:0] PressScale = 16'd50000;
  localparam logic [31:0] PcoefSq    = 32'd3038;
  localparam logic [31:0] PcoefLin   = 32'hFFFF_E343;
  localparam logic [31:0] PcoefOfs   = 32'd3791;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ===== hdl/brc_div.sv =====
module brc_div #(
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [W-1:0]  divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quotient_o,
  output logic [SW-1:0] side_o
);

  logic [W-1:0]  a_q [W];
  logic [W-1:0]  r_q [W];
  logic [W-1:0]  d_q [W];
  logic [SW-1:0] s_q [W];
  logic [W-1:0]  v_q;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]  a_in, r_in, d_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [W:0]    t, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign a_in = dividend_i;
      assign r_in = '0;
      assign d_in = divisor_i;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign a_in = a_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign s_in = s_q[k-1];
      assign v_in = v_q[k-1];
    end

    assign t    = {r_in, a_in[W-1]};
    assign diff = t - {1'b0, d_in};
    assign ge   = (t >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k] <= {a_in[W-2:0], ge};
        r_q[k] <= ge ? diff[W-1:0] : t[W-1:0];
        d_q[k] <= d_in;
        s_q[k] <= s_in;
      end
    end
  end

  assign valid_o    = v_q[W-1];
  assign quotient_o = a_q[W-1];
  assign side_o     = s_q[W-1];

endmodule

// ===== hdl/barometer_reading_compensation.sv =====
// Throughput: one request per cycle while the output is not stalled; two
// 32-stage restoring dividers, one bit per stage, set the depth. A stall on
// the output freezes the whole pipeline.
// Reset: asynchronous, active low; clears all valid bits, the calibration
// words to 0 and the oversampling mode to 3.
module barometer_reading_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [brc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [15:0]                   raw_temperature_i,
  input  logic [23:0]                   raw_pressure_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [15:0]            temperature_deci_c_o,
  output logic signed [31:0]            pressure_pa_o,
  output logic                          divide_fault_o
);

  logic [47:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q, cal_d_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      cal_d_q <= '0;
      oss_q   <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (brc_pkg::cfg_idx_e'(cfg_idx_i))
        brc_pkg::CFG_CAL_A: cal_a_q <= cfg_data_i;
        brc_pkg::CFG_CAL_B: cal_b_q <= cfg_data_i;
        brc_pkg::CFG_CAL_C: cal_c_q <= cfg_data_i[31:0];
        brc_pkg::CFG_CAL_D: cal_d_q <= cfg_data_i[31:0];
        brc_pkg::CFG_OSS:   oss_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = brc_pkg::sx16(cal_a_q[47:32]);
  assign ac2 = brc_pkg::sx16(cal_a_q[31:16]);
  assign ac3 = brc_pkg::sx16(cal_a_q[15:0]);
  assign ac4 = {16'd0, cal_b_q[47:32]};
  assign ac5 = {16'd0, cal_b_q[31:16]};
  assign ac6 = {16'd0, cal_b_q[15:0]};
  assign b1  = brc_pkg::sx16(cal_c_q[31:16]);
  assign b2  = brc_pkg::sx16(cal_c_q[15:0]);
  assign mc  = brc_pkg::sx16(cal_d_q[31:16]);
  assign md  = brc_pkg::sx16(cal_d_q[15:0]);

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // front end up to the temperature divider
  logic        va_q, vb_q, vc_q, vd_q;
  logic [15:0] ut_a_q;
  logic [23:0] up_a_q, up_b_q, up_c_q, up_d_q;
  logic [31:0] p1_b_q, x1_c_q, den_c_q, x1_d_q, absn_d_q, absd_d_q;
  logic        neg_d_q, zt_d_q;

  logic [31:0] num;
  assign num = mc << 11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ut_a_q   <= raw_temperature_i;
      up_a_q   <= raw_pressure_i >> (4'd8 - {2'b00, oss_q});
      p1_b_q   <= ({16'd0, ut_a_q} - ac6) * ac5;
      up_b_q   <= up_a_q;
      x1_c_q   <= brc_pkg::asr32(p1_b_q, 5'd15);
      den_c_q  <= brc_pkg::asr32(p1_b_q, 5'd15) + md;
      up_c_q   <= up_b_q;
      x1_d_q   <= x1_c_q;
      absn_d_q <= num[31] ? (32'd0 - num) : num;
      absd_d_q <= den_c_q[31] ? (32'd0 - den_c_q) : den_c_q;
      neg_d_q  <= num[31] ^ den_c_q[31];
      zt_d_q   <= (den_c_q == 32'd0);
      up_d_q   <= up_c_q;
    end
  end

  logic        v1o;
  logic [31:0] q1o;
  logic [57:0] s1o;

  brc_div #(.W(32), .SW(58)) u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vd_q),
    .dividend_i (absn_d_q),
    .divisor_i  (absd_d_q),
    .side_i     ({x1_d_q, up_d_q, neg_d_q, zt_d_q}),
    .valid_o    (v1o),
    .quotient_o (q1o),
    .side_o     (s1o)
  );

  logic [31:0] x1t, x2t;
  logic [23:0] up1;
  logic        negt, zt;
  assign {x1t, up1, negt, zt} = s1o;
  assign x2t = zt ? 32'd0 : (negt ? (32'd0 - q1o) : q1o);

  // pressure coefficient stages
  logic        ve_q, vf_q, vg_q, vh_q, vi_q, vj_q, vk_q, vl_q, vm_q;
  logic [31:0] b5_e_q, b6_f_q, sq_g_q, m2_g_q, m3_g_q;
  logic [31:0] b6sq_h_q, x2a_h_q, x1c_h_q, m1_i_q, mb_i_q, x2a_i_q, x1c_i_q;
  logic [31:0] x3a_j_q, x3b_j_q, b3_k_q, s_k_q, b4_l_q, d7_l_q, b4_m_q, b7_m_q;
  logic [23:0] up_e_q, up_f_q, up_g_q, up_h_q, up_i_q, up_j_q, up_k_q;
  logic [15:0] t_f_q, t_g_q, t_h_q, t_i_q, t_j_q, t_k_q, t_l_q, t_m_q;
  logic        f_e_q, f_f_q, f_g_q, f_h_q, f_i_q, f_j_q, f_k_q, f_l_q, f_m_q;

  logic [31:0] tsh;
  logic [15:0] tsat;
  assign tsh = brc_pkg::asr32(b5_e_q + 32'd8, 5'd4);
  always_comb begin
    priority if (!tsh[31] && (tsh[30:15] != 16'd0)) tsat = 16'h7FFF;
    else if (tsh[31] && (tsh[30:15] != 16'hFFFF)) tsat = 16'h8000;
    else tsat = tsh[15:0];
  end

  logic [31:0] b3_sum;
  assign b3_sum = ((ac1 << 2) + x3a_j_q) << oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
      vk_q <= 1'b0;
      vl_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en) begin
      ve_q <= v1o;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
      vj_q <= vi_q;
      vk_q <= vj_q;
      vl_q <= vk_q;
      vm_q <= vl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b5_e_q   <= x1t + x2t;
      up_e_q   <= up1;
      f_e_q    <= zt;

      t_f_q    <= tsat;
      b6_f_q   <= b5_e_q - brc_pkg::TempOffset;
      up_f_q   <= up_e_q;
      f_f_q    <= f_e_q;

      sq_g_q   <= b6_f_q * b6_f_q;
      m2_g_q   <= ac2 * b6_f_q;
      m3_g_q   <= ac3 * b6_f_q;
      t_g_q    <= t_f_q;
      up_g_q   <= up_f_q;
      f_g_q    <= f_f_q;

      b6sq_h_q <= brc_pkg::asr32(sq_g_q, 5'd12);
      x2a_h_q  <= brc_pkg::asr32(m2_g_q, 5'd11);
      x1c_h_q  <= brc_pkg::asr32(m3_g_q, 5'd13);
      t_h_q    <= t_g_q;
      up_h_q   <= up_g_q;
      f_h_q    <= f_g_q;

      m1_i_q   <= b2 * b6sq_h_q;
      mb_i_q   <= b1 * b6sq_h_q;
      x2a_i_q  <= x2a_h_q;
      x1c_i_q  <= x1c_h_q;
      t_i_q    <= t_h_q;
      up_i_q   <= up_h_q;
      f_i_q    <= f_h_q;

      x3a_j_q  <= brc_pkg::asr32(m1_i_q, 5'd11) + x2a_i_q;
      x3b_j_q  <= brc_pkg::asr32(brc_pkg::asr32(mb_i_q, 5'd16) + x1c_i_q + 32'd2, 5'd2);
      t_j_q    <= t_i_q;
      up_j_q   <= up_i_q;
      f_j_q    <= f_i_q;

      b3_k_q   <= brc_pkg::asr32(b3_sum + 32'd2, 5'd2);
      s_k_q    <= x3b_j_q + brc_pkg::Half15;
      t_k_q    <= t_j_q;
      up_k_q   <= up_j_q;
      f_k_q    <= f_j_q;

      b4_l_q   <= (ac4 * s_k_q) >> 15;
      d7_l_q   <= {8'd0, up_k_q} - b3_k_q;
      t_l_q    <= t_k_q;
      f_l_q    <= f_k_q;

      b4_m_q   <= b4_l_q;
      b7_m_q   <= d7_l_q * {16'd0, brc_pkg::PressScale >> oss_q};
      t_m_q    <= t_l_q;
      f_m_q    <= f_l_q;
    end
  end

  logic        lt;
  logic [31:0] dvd2;
  assign lt   = !b7_m_q[31];
  assign dvd2 = lt ? (b7_m_q << 1) : b7_m_q;

  logic        v2o;
  logic [31:0] q2o;
  logic [18:0] s2o;

  brc_div #(.W(32), .SW(19)) u_div_p (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vm_q),
    .dividend_i (dvd2),
    .divisor_i  (b4_m_q),
    .side_i     ({t_m_q, f_m_q, lt, (b4_m_q == 32'd0)}),
    .valid_o    (v2o),
    .quotient_o (q2o),
    .side_o     (s2o)
  );

  logic [15:0] t2;
  logic        f2, lt2, zp;
  assign {t2, f2, lt2, zp} = s2o;

  // pressure correction
  logic        vn_q, vo_q, vp_q, vq_q;
  logic [31:0] p_n_q, p_o_q, sq_o_q, pm_o_q, p_p_q, m_p_q, x2_p_q;
  logic [15:0] t_n_q, t_o_q, t_p_q;
  logic        f_n_q, f_o_q, f_p_q;
  logic [31:0] pa;
  assign pa = brc_pkg::asr32(p_n_q, 5'd8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
      vo_q <= 1'b0;
      vp_q <= 1'b0;
      vq_q <= 1'b0;
    end else if (en) begin
      vn_q <= v2o;
      vo_q <= vn_q;
      vp_q <= vo_q;
      vq_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_n_q  <= zp ? 32'd0 : (lt2 ? q2o : (q2o << 1));
      t_n_q  <= t2;
      f_n_q  <= f2 | zp;

      sq_o_q <= pa * pa;
      pm_o_q <= p_n_q * brc_pkg::PcoefLin;
      p_o_q  <= p_n_q;
      t_o_q  <= t_n_q;
      f_o_q  <= f_n_q;

      m_p_q  <= sq_o_q * brc_pkg::PcoefSq;
      x2_p_q <= brc_pkg::asr32(pm_o_q, 5'd16);
      p_p_q  <= p_o_q;
      t_p_q  <= t_o_q;
      f_p_q  <= f_o_q;

      pressure_pa_o <= p_p_q + brc_pkg::asr32(
        brc_pkg::asr32(m_p_q, 5'd16) + x2_p_q + brc_pkg::PcoefOfs, 5'd4);
      temperature_deci_c_o <= t_p_q;
      divide_fault_o       <= f_p_q;
    end
  end

  assign valid_o = vq_q;

endmodule
